// File: hw/rtl/bba_pkg.sv
// Shared constants, types and helpers of the buddy block allocator.
package bba_pkg;

  localparam int ORDERS     = 16;
  localparam int UNIT_SHIFT = 5;
  localparam int UNIT_W     = ORDERS - 1;
  localparam int UNITS      = 1 << UNIT_W;
  localparam int ORD_W      = $clog2(ORDERS);
  localparam int CFG_W      = 4;
  localparam int SIZE_W     = 21;
  localparam int ADDR_W     = 20;
  localparam int NEED_W     = SIZE_W + 1;
  localparam int OW         = $clog2(NEED_W + 1);
  localparam int HDR_BYTES  = 16;
  localparam int CFG_RESET  = 15;
  localparam logic [3:0] ALIGN_MASK = 4'hF;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOMEM    = 2'd1,
    STAT_BAD_SIZE = 2'd2,
    STAT_BAD_ADDR = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    US_NONE = 2'd0,
    US_FREE = 2'd1,
    US_USED = 2'd2
  } unit_st_e;

  typedef enum logic [3:0] {
    OP_IDLE      = 4'd0,
    OP_ACCEPT    = 4'd1,
    OP_CLEAR     = 4'd2,
    OP_DECODE    = 4'd3,
    OP_SEARCH    = 4'd4,
    OP_REMOVE    = 4'd5,
    OP_SPLIT_A   = 4'd6,
    OP_SPLIT_B   = 4'd7,
    OP_ALLOC_TAG = 4'd8,
    OP_FREE_TAG  = 4'd9,
    OP_MERGE_CHK = 4'd10,
    OP_MERGE_TST = 4'd11,
    OP_PUSH_A    = 4'd12,
    OP_PUSH_B    = 4'd13
  } op_e;

  typedef struct packed {
    logic              v;
    logic [UNIT_W-1:0] idx;
  } link_t;

  typedef struct packed {
    logic [ORD_W-1:0] ord;
    unit_st_e         st;
  } meta_t;

  typedef struct packed {
    op_e  op;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cmd_free;
    logic err;
    logic k_gt_order;
    logic k1_gt_order;
    logic merge_go;
    logic buddy_ok;
    logic clear_last;
  } dp_status_t;

  function automatic logic [ORD_W-1:0] eff_pool(input logic [CFG_W-1:0] v);
    logic [ORD_W-1:0] r;
    if (32'(v) > ORDERS - 1) begin
      r = ORD_W'(ORDERS - 1);
    end else begin
      r = ORD_W'(v);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/bba_if.sv
// Word channels of the allocator: requests, responses and configuration.
interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [bba_pkg::SIZE_W-1:0]  request_size;
  logic [bba_pkg::ADDR_W-1:0]  free_address;
  modport source (output valid, cmd, request_size, free_address, input ready);
  modport sink   (input valid, cmd, request_size, free_address, output ready);
endinterface

interface bba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [bba_pkg::ADDR_W-1:0]  address;
  modport source (output valid, status, address, input ready);
  modport sink   (input valid, status, address, output ready);
endinterface

interface bba_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::CFG_W-1:0]   pool_order;
  modport source (output valid, pool_order, input ready);
  modport sink   (input valid, pool_order, output ready);
endinterface

// File: hw/rtl/bba_ctrl.sv
// Sequencing state machine of the allocator.
module bba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  logic                cfg_wr_i,
  input  bba_pkg::dp_status_t dp_status_i,
  output bba_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [13:0] {
    S_CLEAR     = 14'h0001,
    S_IDLE      = 14'h0002,
    S_DECODE    = 14'h0004,
    S_SEARCH    = 14'h0008,
    S_REMOVE    = 14'h0010,
    S_SPLIT_A   = 14'h0020,
    S_SPLIT_B   = 14'h0040,
    S_ALLOC_TAG = 14'h0080,
    S_FREE_TAG  = 14'h0100,
    S_MERGE_CHK = 14'h0200,
    S_MERGE_TST = 14'h0400,
    S_PUSH_A    = 14'h0800,
    S_PUSH_B    = 14'h1000,
    S_FINISH    = 14'h2000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = bba_pkg::OP_IDLE;
    cmd_o.load_out = 1'b0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = bba_pkg::OP_CLEAR;
        if (dp_status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = bba_pkg::OP_ACCEPT;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.op = bba_pkg::OP_DECODE;
        if (!dp_status_i.cmd_free) state_d = S_SEARCH;
        else if (dp_status_i.err) state_d = S_FINISH;
        else state_d = S_FREE_TAG;
      end
      S_SEARCH: begin
        cmd_o.op = bba_pkg::OP_SEARCH;
        state_d  = dp_status_i.err ? S_FINISH : S_REMOVE;
      end
      S_REMOVE: begin
        cmd_o.op = bba_pkg::OP_REMOVE;
        state_d  = dp_status_i.k_gt_order ? S_SPLIT_A : S_ALLOC_TAG;
      end
      S_SPLIT_A: begin
        cmd_o.op = bba_pkg::OP_SPLIT_A;
        state_d  = S_SPLIT_B;
      end
      S_SPLIT_B: begin
        cmd_o.op = bba_pkg::OP_SPLIT_B;
        state_d  = dp_status_i.k1_gt_order ? S_SPLIT_A : S_ALLOC_TAG;
      end
      S_ALLOC_TAG: begin
        cmd_o.op = bba_pkg::OP_ALLOC_TAG;
        state_d  = S_FINISH;
      end
      S_FREE_TAG: begin
        cmd_o.op = bba_pkg::OP_FREE_TAG;
        state_d  = dp_status_i.err ? S_FINISH : S_MERGE_CHK;
      end
      S_MERGE_CHK: begin
        cmd_o.op = bba_pkg::OP_MERGE_CHK;
        state_d  = dp_status_i.merge_go ? S_MERGE_TST : S_PUSH_A;
      end
      S_MERGE_TST: begin
        cmd_o.op = bba_pkg::OP_MERGE_TST;
        state_d  = dp_status_i.buddy_ok ? S_MERGE_CHK : S_PUSH_A;
      end
      S_PUSH_A: begin
        cmd_o.op = bba_pkg::OP_PUSH_A;
        state_d  = S_PUSH_B;
      end
      S_PUSH_B: begin
        cmd_o.op = bba_pkg::OP_PUSH_B;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    if (cfg_wr_i) state_d = S_CLEAR;
  end

  always_comb begin
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/bba_datapath.sv
// Datapath of the allocator: free list heads, unit stores and result registers.
module bba_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bba_pkg::ctrl_cmd_t            cmd_i,
  input  logic                          cfg_wr_i,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          cmd_in_i,
  input  logic [bba_pkg::SIZE_W-1:0]    size_in_i,
  input  logic [bba_pkg::ADDR_W-1:0]    faddr_in_i,
  output bba_pkg::dp_status_t           status_o,
  output bba_pkg::status_e              out_status_o,
  output logic [bba_pkg::ADDR_W-1:0]    out_address_o
);

  localparam int UW = bba_pkg::UNIT_W;
  localparam int KW = bba_pkg::ORD_W;
  localparam int OW = bba_pkg::OW;
  localparam int AW = bba_pkg::ADDR_W;
  localparam int NW = bba_pkg::NEED_W;
  localparam int XW = UW + bba_pkg::UNIT_SHIFT + 1;

  bba_pkg::link_t   head_q [bba_pkg::ORDERS];
  logic [bba_pkg::CFG_W-1:0] pool_q;
  logic [UW-1:0]    cnt_q;

  bba_pkg::meta_t   meta_mem [bba_pkg::UNITS];
  bba_pkg::link_t   next_mem [bba_pkg::UNITS];
  bba_pkg::link_t   prev_mem [bba_pkg::UNITS];
  bba_pkg::meta_t   meta_rd_q;
  bba_pkg::link_t   next_rd_q, prev_rd_q;

  logic                         cmd_q, zero_q;
  logic [bba_pkg::SIZE_W-1:0]   size_q;
  logic [AW-1:0]                faddr_q;
  logic [OW-1:0]                order_q;
  logic [UW-1:0]                u_q;
  logic [KW-1:0]                k_q;
  bba_pkg::status_e             res_status_q, out_status_q;
  logic [AW-1:0]                res_addr_q, out_addr_q;

  logic [KW-1:0]    eff_p, jf, pk;
  logic [NW-1:0]    need, nm1;
  logic [OW-1:0]    fl, s_w, ord_w;
  logic [AW-1:0]    h, uf;
  logic             free_err, found, search_bad, buddy_ok, rm_en;
  bba_pkg::status_e search_code;
  bba_pkg::link_t   head_j, push_h, rm_link;
  logic [UW-1:0]    b, rm_r;
  logic [XW-1:0]    addr_full;

  logic             meta_we, next_we, prev_we;
  logic [UW-1:0]    meta_wa, next_wa, prev_wa, meta_ra, link_ra;
  bba_pkg::meta_t   meta_wd;
  bba_pkg::link_t   next_wd, prev_wd;

  assign eff_p = bba_pkg::eff_pool(pool_q);

  always_comb begin
    need = NW'(size_q) + NW'(bba_pkg::HDR_BYTES);
    nm1  = need - NW'(1);
    fl   = '0;
    for (int i = 0; i < NW; i++) begin
      if (nm1[i]) fl = OW'(i);
    end
    s_w   = fl + OW'(1);
    ord_w = (s_w > OW'(bba_pkg::UNIT_SHIFT)) ? s_w - OW'(bba_pkg::UNIT_SHIFT) : '0;
  end

  always_comb begin
    h  = faddr_q - AW'(bba_pkg::HDR_BYTES);
    uf = h >> bba_pkg::UNIT_SHIFT;
    free_err = (faddr_q < AW'(bba_pkg::HDR_BYTES))
            || ((faddr_q[3:0] & bba_pkg::ALIGN_MASK) != 4'd0)
            || (h[bba_pkg::UNIT_SHIFT-1:0] != '0)
            || ((uf >> eff_p) != '0);
  end

  always_comb begin
    found = 1'b0;
    jf    = '0;
    for (int j = bba_pkg::ORDERS - 1; j >= 0; j--) begin
      if ((OW'(j) >= order_q) && head_q[j].v) begin
        found = 1'b1;
        jf    = KW'(j);
      end
    end
    head_j     = head_q[jf];
    search_bad = zero_q || (order_q >= OW'(bba_pkg::ORDERS)) || !found;
    if (zero_q || (order_q >= OW'(bba_pkg::ORDERS))) search_code = bba_pkg::STAT_BAD_SIZE;
    else if (!found) search_code = bba_pkg::STAT_NOMEM;
    else search_code = bba_pkg::STAT_OK;
  end

  always_comb begin
    b        = u_q ^ (UW'(1) << k_q);
    buddy_ok = (meta_rd_q.st == bba_pkg::US_FREE) && (meta_rd_q.ord == k_q);
    rm_r     = (cmd_i.op == bba_pkg::OP_MERGE_TST) ? b : u_q;
    rm_link  = '{v: 1'b1, idx: rm_r};
    rm_en    = (cmd_i.op == bba_pkg::OP_REMOVE)
            || ((cmd_i.op == bba_pkg::OP_MERGE_TST) && buddy_ok);
    pk       = ((cmd_i.op == bba_pkg::OP_SPLIT_A) || (cmd_i.op == bba_pkg::OP_SPLIT_B))
               ? k_q - KW'(1) : k_q;
    push_h   = head_q[pk];
    addr_full = (XW'(u_q) << bba_pkg::UNIT_SHIFT) + XW'(bba_pkg::HDR_BYTES);
  end

  always_comb begin
    status_o.cmd_free    = cmd_q;
    status_o.k_gt_order  = OW'(k_q) > order_q;
    status_o.k1_gt_order = OW'(k_q - KW'(1)) > order_q;
    status_o.merge_go    = k_q < eff_p;
    status_o.buddy_ok    = buddy_ok;
    status_o.clear_last  = &cnt_q;
    unique case (cmd_i.op)
      bba_pkg::OP_DECODE:   status_o.err = cmd_q && free_err;
      bba_pkg::OP_SEARCH:   status_o.err = search_bad;
      bba_pkg::OP_FREE_TAG: status_o.err = meta_rd_q.st != bba_pkg::US_USED;
      default:              status_o.err = 1'b0;
    endcase
  end

  always_comb begin
    meta_we = 1'b0;
    next_we = 1'b0;
    prev_we = 1'b0;
    meta_wa = u_q;
    next_wa = u_q;
    prev_wa = u_q;
    meta_wd = '0;
    next_wd = '0;
    prev_wd = '0;
    meta_ra = (cmd_i.op == bba_pkg::OP_MERGE_CHK) ? b : uf[UW-1:0];
    link_ra = (cmd_i.op == bba_pkg::OP_MERGE_CHK) ? b : head_j.idx;
    unique case (cmd_i.op) inside
      bba_pkg::OP_CLEAR: begin
        meta_we = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        meta_wa = cnt_q;
        next_wa = cnt_q;
        prev_wa = cnt_q;
        if (cnt_q == '0) meta_wd = '{ord: eff_p, st: bba_pkg::US_FREE};
      end
      bba_pkg::OP_REMOVE, bba_pkg::OP_MERGE_TST: begin
        if (rm_en) begin
          next_we = prev_rd_q.v;
          next_wa = prev_rd_q.idx;
          next_wd = next_rd_q;
          prev_we = next_rd_q.v;
          prev_wa = next_rd_q.idx;
          prev_wd = prev_rd_q;
          if (cmd_i.op == bba_pkg::OP_MERGE_TST) begin
            meta_we = 1'b1;
            meta_wa = (b < u_q) ? u_q : b;
            meta_wd = '{ord: k_q, st: bba_pkg::US_NONE};
          end
        end
      end
      bba_pkg::OP_SPLIT_A, bba_pkg::OP_PUSH_A: begin
        meta_we = 1'b1;
        meta_wd = '{ord: pk, st: bba_pkg::US_FREE};
        next_we = 1'b1;
        next_wd = push_h;
        prev_we = 1'b1;
      end
      bba_pkg::OP_SPLIT_B, bba_pkg::OP_PUSH_B: begin
        prev_we = push_h.v;
        prev_wa = push_h.idx;
        prev_wd = '{v: 1'b1, idx: u_q};
      end
      bba_pkg::OP_ALLOC_TAG: begin
        meta_we = 1'b1;
        meta_wd = '{ord: order_q[KW-1:0], st: bba_pkg::US_USED};
      end
      default: begin
        meta_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    meta_rd_q <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_q <= next_mem[link_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd_q <= prev_mem[link_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= bba_pkg::CFG_W'(bba_pkg::CFG_RESET);
      cnt_q  <= '0;
      for (int i = 0; i < bba_pkg::ORDERS; i++) begin
        if (KW'(i) == bba_pkg::eff_pool(bba_pkg::CFG_W'(bba_pkg::CFG_RESET))) begin
          head_q[i] <= '{v: 1'b1, idx: '0};
        end else begin
          head_q[i] <= '0;
        end
      end
    end else if (cfg_wr_i) begin
      pool_q <= cfg_data_i;
      cnt_q  <= '0;
      for (int i = 0; i < bba_pkg::ORDERS; i++) begin
        if (KW'(i) == bba_pkg::eff_pool(cfg_data_i)) begin
          head_q[i] <= '{v: 1'b1, idx: '0};
        end else begin
          head_q[i] <= '0;
        end
      end
    end else begin
      if (cmd_i.op == bba_pkg::OP_CLEAR) cnt_q <= cnt_q + UW'(1);
      if (rm_en && (head_q[k_q] == rm_link)) head_q[k_q] <= next_rd_q;
      if ((cmd_i.op == bba_pkg::OP_SPLIT_B) || (cmd_i.op == bba_pkg::OP_PUSH_B)) begin
        head_q[pk] <= '{v: 1'b1, idx: u_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      bba_pkg::OP_ACCEPT: begin
        cmd_q   <= cmd_in_i;
        size_q  <= size_in_i;
        faddr_q <= faddr_in_i;
      end
      bba_pkg::OP_DECODE: begin
        res_addr_q <= '0;
        order_q    <= ord_w;
        zero_q     <= size_q == '0;
        u_q        <= uf[UW-1:0];
        res_status_q <= free_err ? bba_pkg::STAT_BAD_ADDR : bba_pkg::STAT_OK;
      end
      bba_pkg::OP_SEARCH: begin
        res_status_q <= search_code;
        u_q          <= head_j.idx;
        k_q          <= jf;
      end
      bba_pkg::OP_SPLIT_B: begin
        u_q <= u_q + (UW'(1) << pk);
        k_q <= pk;
      end
      bba_pkg::OP_ALLOC_TAG: begin
        res_status_q <= bba_pkg::STAT_OK;
        res_addr_q   <= addr_full[AW-1:0];
      end
      bba_pkg::OP_FREE_TAG: begin
        k_q <= meta_rd_q.ord;
        res_status_q <= (meta_rd_q.st == bba_pkg::US_USED) ? bba_pkg::STAT_OK
                                                           : bba_pkg::STAT_BAD_ADDR;
      end
      bba_pkg::OP_MERGE_TST: begin
        if (buddy_ok) begin
          k_q <= k_q + KW'(1);
          if (b < u_q) u_q <= b;
        end
      end
      bba_pkg::OP_PUSH_B: begin
        res_status_q <= bba_pkg::STAT_OK;
      end
      default: begin
        res_addr_q <= res_addr_q;
      end
    endcase
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
    end
  end

  assign out_status_o  = out_status_q;
  assign out_address_o = out_addr_q;

endmodule

// File: hw/rtl/buddy_block_allocator.sv
// Top level of the buddy block allocator.
// Allocate: the search is followed by n splits (0..15), each a SPLIT_A and a SPLIT_B step.
// Free: the tag check is followed by m merges (0..15), each a MERGE_CHK and a MERGE_TST step;
// a busy buddy ends the merging after its test; rejected requests answer without these steps.
// Each split or merge is a two-step read-modify-write on the unit stores.
// After reset and after every pool_order write a clearing pass runs over the unit stores;
// no request is accepted until it ends.
module buddy_block_allocator (
  input  logic      clk_i,
  input  logic      rst_ni,
  bba_req_if.sink   req_i,
  bba_rsp_if.source rsp_o,
  bba_cfg_if.sink   cfg_i
);

  bba_pkg::ctrl_cmd_t  cmd;
  bba_pkg::dp_status_t dp_status;
  bba_pkg::status_e    out_status;
  logic                cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .cfg_wr_i    (cfg_wr),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  bba_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_wr_i      (cfg_wr),
    .cfg_data_i    (cfg_i.pool_order),
    .cmd_in_i      (req_i.cmd),
    .size_in_i     (req_i.request_size),
    .faddr_in_i    (req_i.free_address),
    .status_o      (dp_status),
    .out_status_o  (out_status),
    .out_address_o (rsp_o.address)
  );

  assign rsp_o.status = out_status;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while busy");

  a_clear_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> !req_i.ready)
    else $error("request taken during clearing pass");

  a_error_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != bba_pkg::STAT_OK)) |-> (rsp_o.address == '0))
    else $error("error response carries an address");

endmodule

// File: tb/tb.sv
// Self-checking testbench of the buddy block allocator with a shadow allocator scoreboard.
`timescale 1ns / 1ps

class alloc_shadow;
  int heads[bba_pkg::ORDERS];
  int nxt[bba_pkg::UNITS];
  int prv[bba_pkg::UNITS];
  bit [3:0] ord[bba_pkg::UNITS];
  bba_pkg::unit_st_e ust[bba_pkg::UNITS];
  int pool;
  int live[$];
  int stale[$];
  bba_pkg::status_e want_st[$];
  bit [19:0] want_addr[$];
  int err_count;
  int ok_allocs;
  int ok_frees;
  int rejects;

  function void push_free(int k, int u);
    int h;
    h = heads[k];
    prv[u] = -1;
    nxt[u] = h;
    if (h >= 0) begin
      prv[h] = u;
    end
    heads[k] = u;
  endfunction

  function void unlink(int k, int u);
    int p;
    int n;
    p = prv[u];
    n = nxt[u];
    if (heads[k] == u) begin
      heads[k] = n;
    end
    if (p >= 0) begin
      nxt[p] = n;
    end
    if (n >= 0) begin
      prv[n] = p;
    end
  endfunction

  function void reset_pool(bit [3:0] v);
    pool = (v > bba_pkg::ORDERS - 1) ? bba_pkg::ORDERS - 1 : v;
    foreach (heads[i]) begin
      heads[i] = -1;
    end
    foreach (ust[i]) begin
      ust[i] = bba_pkg::US_NONE;
    end
    ord[0] = 4'(pool);
    ust[0] = bba_pkg::US_FREE;
    push_free(pool, 0);
    live.delete();
    stale.delete();
  endfunction

  function bba_pkg::status_e carve(bit [20:0] size, output bit [19:0] addr);
    longint need;
    int s;
    int order;
    int j;
    int u;
    addr = '0;
    need = longint'(size) + bba_pkg::HDR_BYTES;
    if (size == 0) begin
      return bba_pkg::STAT_BAD_SIZE;
    end
    s = 0;
    while (s < 31 && (64'd1 << s) < need) begin
      s++;
    end
    order = (s > bba_pkg::UNIT_SHIFT) ? s - bba_pkg::UNIT_SHIFT : 0;
    if (order >= bba_pkg::ORDERS) begin
      return bba_pkg::STAT_BAD_SIZE;
    end
    j = order;
    while (j < bba_pkg::ORDERS && heads[j] < 0) begin
      j++;
    end
    if (j >= bba_pkg::ORDERS) begin
      return bba_pkg::STAT_NOMEM;
    end
    u = heads[j];
    unlink(j, u);
    for (int k = j; k > order; k--) begin
      ord[u] = 4'(k - 1);
      ust[u] = bba_pkg::US_FREE;
      push_free(k - 1, u);
      u = (u + (1 << (k - 1))) & (bba_pkg::UNITS - 1);
      ord[u] = 4'(k - 1);
    end
    ust[u] = bba_pkg::US_USED;
    addr = 20'((u << bba_pkg::UNIT_SHIFT) + bba_pkg::HDR_BYTES);
    return bba_pkg::STAT_OK;
  endfunction

  function bba_pkg::status_e release_block(bit [19:0] a);
    int h;
    int u;
    int k;
    int b;
    if (a < bba_pkg::HDR_BYTES || (a & bba_pkg::ALIGN_MASK) != 0) begin
      return bba_pkg::STAT_BAD_ADDR;
    end
    h = a - bba_pkg::HDR_BYTES;
    if ((h & ((1 << bba_pkg::UNIT_SHIFT) - 1)) != 0) begin
      return bba_pkg::STAT_BAD_ADDR;
    end
    u = h >> bba_pkg::UNIT_SHIFT;
    if (u >= (1 << pool) || ust[u] != bba_pkg::US_USED) begin
      return bba_pkg::STAT_BAD_ADDR;
    end
    k = ord[u];
    while (k < pool) begin
      b = (u ^ (1 << k)) & (bba_pkg::UNITS - 1);
      if (ust[b] != bba_pkg::US_FREE || ord[b] != k) begin
        break;
      end
      unlink(k, b);
      if (b < u) begin
        ust[u] = bba_pkg::US_NONE;
        u = b;
      end else begin
        ust[b] = bba_pkg::US_NONE;
      end
      k++;
      ord[u] = 4'(k);
    end
    ord[u] = 4'(k);
    ust[u] = bba_pkg::US_FREE;
    push_free(k, u);
    return bba_pkg::STAT_OK;
  endfunction

  function void note_request(bit cmd, bit [20:0] size, bit [19:0] fa);
    bba_pkg::status_e st;
    bit [19:0] addr;
    addr = '0;
    if (cmd == 1'b0) begin
      st = carve(size, addr);
      if (st == bba_pkg::STAT_OK) begin
        live.push_back(addr);
        ok_allocs++;
      end
    end else begin
      st = release_block(fa);
      if (st == bba_pkg::STAT_OK) begin
        foreach (live[i]) begin
          if (live[i] == fa) begin
            live.delete(i);
            break;
          end
        end
        stale.push_back(fa);
        if (stale.size() > 64) begin
          void'(stale.pop_front());
        end
        ok_frees++;
      end
    end
    if (st != bba_pkg::STAT_OK) begin
      rejects++;
    end
    want_st.push_back(st);
    want_addr.push_back(addr);
  endfunction

  function void check_response(bit [1:0] st, bit [19:0] addr);
    bba_pkg::status_e es;
    bit [19:0] ea;
    if (want_st.size() == 0) begin
      $error("unexpected response: status %0d address %0h", st, addr);
      err_count++;
      return;
    end
    es = want_st.pop_front();
    ea = want_addr.pop_front();
    if (st != es) begin
      $error("status: expected %0d, got %0d", es, st);
      err_count++;
    end
    if (addr != ea) begin
      $error("address: expected %0h, got %0h", ea, addr);
      err_count++;
    end
  endfunction
endclass

module tb;
  logic clk;
  logic rst_n;
  int cycles;
  int rsp_tick;
  alloc_shadow shadow;

  bba_req_if req();
  bba_rsp_if rsp();
  bba_cfg_if cfg();

  buddy_block_allocator DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      shadow.check_response(rsp.status, rsp.address);
    end
  end

  always @(negedge clk) begin
    rsp_tick++;
    case ((rsp_tick / 97) % 4)
      0: begin
        rsp.ready <= 1'b1;
      end
      1: begin
        rsp.ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        rsp.ready <= (rsp_tick % 5 == 0);
      end
      default: begin
        rsp.ready <= ($urandom_range(0, 9) != 0);
      end
    endcase
  end

  task automatic send_word(bit cmd, bit [20:0] size, bit [19:0] fa);
    @(negedge clk);
    req.valid = 1'b1;
    req.cmd = cmd;
    req.request_size = size;
    req.free_address = fa;
    @(posedge clk);
    while (req.ready !== 1'b1) begin
      @(posedge clk);
    end
    shadow.note_request(cmd, size, fa);
  endtask

  task automatic hold_gap(int n);
    @(negedge clk);
    req.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (shadow.want_st.size() != 0) begin
      @(posedge clk);
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic write_pool(bit [3:0] v);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.pool_order = v;
    @(posedge clk);
    while (cfg.ready !== 1'b1) begin
      @(posedge clk);
    end
    shadow.reset_pool(v);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic random_words(int n, bit gaps);
    int burst;
    int r;
    bit [20:0] size;
    bit [19:0] fa;
    burst = $urandom_range(1, 20);
    repeat (n) begin
      r = $urandom_range(0, 99);
      size = 21'($urandom);
      fa = 20'($urandom);
      if (r < 45) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          size = 21'($urandom_range(1, 200));
        end else if (r < 90) begin
          size = 21'($urandom_range(1, 4000));
        end else if (r < 98) begin
          size = 21'($urandom_range(1, 70000));
        end
        send_word(1'b0, size, fa);
      end else if (r < 85 && shadow.live.size() != 0) begin
        fa = 20'(shadow.live[$urandom_range(0, shadow.live.size() - 1)]);
        send_word(1'b1, size, fa);
      end else begin
        case ($urandom_range(0, 6))
          0: send_word(1'b0, 21'd0, fa);
          1: send_word(1'b0, size, fa);
          2: send_word(1'b0, 21'd1048560, fa);
          3: send_word(1'b1, size, fa);
          4: send_word(1'b1, size, (shadow.stale.size() != 0) ?
                       20'(shadow.stale[$urandom_range(0, shadow.stale.size() - 1)]) : fa);
          5: send_word(1'b1, size, (shadow.live.size() != 0) ?
                       20'(shadow.live[$urandom_range(0, shadow.live.size() - 1)] + 32)
                       : fa);
          default: send_word(1'b1, size, fa & 20'hFFFF0);
        endcase
      end
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if (gaps) begin
          hold_gap($urandom_range(1, 8));
        end
      end
    end
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  initial begin
    shadow = new();
    shadow.reset_pool(4'(bba_pkg::CFG_RESET));
    req.valid = 1'b0;
    req.cmd = 1'b0;
    req.request_size = '0;
    req.free_address = '0;
    cfg.valid = 1'b0;
    cfg.pool_order = '0;
    rsp.ready = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_word(1'b0, 21'd1, 20'd0);
    send_word(1'b0, 21'd1048560, 20'd0);
    send_word(1'b0, 21'd0, 20'hFFFFF);
    send_word(1'b0, 21'd1048576, 20'd0);
    send_word(1'b0, 21'h1FFFFF, 20'd0);
    send_word(1'b1, 21'h1FFFFF, 20'd0);
    send_word(1'b1, 21'd0, 20'd8);
    send_word(1'b1, 21'd0, 20'd48);
    send_word(1'b1, 21'd0, 20'd16);
    send_word(1'b1, 21'd0, 20'd16);
    send_word(1'b1, 21'd0, 20'hFFFF0);
    send_word(1'b1, 21'd0, 20'hFFFFF);
    send_word(1'b0, 21'd1048560, 20'd0);
    send_word(1'b0, 21'd16, 20'd0);
    send_word(1'b1, 21'd0, 20'd16);
    send_word(1'b0, 21'd48, 20'd0);
    send_word(1'b0, 21'd100, 20'd0);
    send_word(1'b1, 21'd0, 20'd208);
    send_word(1'b1, 21'd0, 20'd144);
    send_word(1'b1, 21'd0, 20'd16);
    send_word(1'b1, 21'd0, 20'd144);
    @(negedge clk);
    req.valid = 1'b0;
    random_words(380, 1'b1);
    drain();

    write_pool(4'd0);
    send_word(1'b0, 21'd16, 20'd0);
    send_word(1'b0, 21'd17, 20'd0);
    send_word(1'b1, 21'd0, 20'd16);
    send_word(1'b1, 21'd0, 20'd48);
    random_words(200, 1'b1);
    drain();

    write_pool(4'd3);
    random_words(300, 1'b0);
    drain();

    write_pool(4'd15);
    random_words(400, 1'b1);
    drain();

    write_pool(4'd9);
    random_words(300, 1'b1);
    drain();

    $display("covered %0d good allocations, %0d good frees, %0d rejected words",
             shadow.ok_allocs, shadow.ok_frees, shadow.rejects);
    $display("over pool orders 15, 0, 3, 15 and 9 with random stalls on both channels");
    if (shadow.err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_if.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bba_datapath.sv
hw/rtl/buddy_block_allocator.sv
tb/tb.sv
